// ===== hdl/rbee_pkg.sv =====
// ---------------------------------------------------------------------------
// rbee_pkg: shared types and constants for the binary row edge extractor
// Holds field widths, the row terminator code and the queue entry type that
// passes classified bytes from the front part to the back part.
// ---------------------------------------------------------------------------
package rbee_pkg;

	// Field widths fixed by the stream format.
	localparam int PIX_W = 8;
	localparam int COL_W = 5;
	localparam int IDX_W = 16;
	localparam int CNT_ADD_W = 4;

	// Value emitted after the last byte of a row.
	localparam logic [PIX_W-1:0] ROW_END_MARK = 8'hFF;

	// Largest output index; the index saturates here.
	localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;

	// Depth of the queue between front and back, and its pointer width.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// One classified byte: transition mask (bit 7 is the leftmost pixel),
	// byte column, row end flag, first-edge flag and index of its first result.
	typedef struct packed {
		logic [PIX_W-1:0] mask;
		logic [COL_W-1:0] col;
		logic             row_end;
		logic             first;
		logic [IDX_W-1:0] base;
	} rbee_entry_t;

endpackage

// ===== hdl/rbee_queue.sv =====
// ---------------------------------------------------------------------------
// rbee_queue: short queue between the classifier and the emitter
// A small first-in first-out store of classified bytes so that the input
// side and the result side can stall independently.
// ---------------------------------------------------------------------------
module rbee_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rbee_pkg::rbee_entry_t din,
	output logic                 full,
	input  logic                 pop,
	output rbee_pkg::rbee_entry_t dout,
	output logic                 empty
);

	rbee_pkg::rbee_entry_t         mem_q [rbee_pkg::QUEUE_DEPTH];
	logic [rbee_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [rbee_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [rbee_pkg::QPTR_W:0]     fill_q;

	assign full  = (fill_q == (rbee_pkg::QPTR_W+1)'(rbee_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/rbee_front.sv =====
// ---------------------------------------------------------------------------
// rbee_front: input classifier of the binary row edge extractor
// Accepts one packed pixel byte per request, finds its transitions, tracks
// the row position and reserves the output indices that its results use.
// ---------------------------------------------------------------------------
module rbee_front #(
	parameter int BYTES_PER_ROW = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rbee_pkg::PIX_W-1:0]   pixel_byte,
	input  logic                         frame_start,
	output logic                         push,
	output rbee_pkg::rbee_entry_t        entry,
	input  logic                         full
);

	logic                         prev_q;
	logic [rbee_pkg::COL_W-1:0]   col_q;
	logic [rbee_pkg::IDX_W-1:0]   cnt_q;
	logic                         has_edge_q;

	logic                         prev_c;
	logic [rbee_pkg::COL_W-1:0]   col_c;
	logic [rbee_pkg::IDX_W-1:0]   cnt_c;
	logic                         has_edge_c;
	logic [rbee_pkg::PIX_W-1:0]   mask;
	logic [rbee_pkg::COL_W-1:0]   col_next;
	logic                         row_end;
	logic [rbee_pkg::CNT_ADD_W-1:0] n_res;
	logic [rbee_pkg::IDX_W:0]     cnt_sum;
	logic [rbee_pkg::IDX_W-1:0]   cnt_next;
	logic                         accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// A frame start clears the row state before the byte is looked at.
	always_comb begin
		prev_c     = frame_start ? 1'b0 : prev_q;
		col_c      = frame_start ? '0 : col_q;
		cnt_c      = frame_start ? '0 : cnt_q;
		has_edge_c = frame_start ? 1'b0 : has_edge_q;
	end

	// Each pixel is compared with its left neighbour; the leftmost with the
	// last pixel of the previous byte.
	assign mask     = pixel_byte ^ {prev_c, pixel_byte[rbee_pkg::PIX_W-1:1]};
	assign col_next = col_c + 1'b1;
	assign row_end  = (col_next == '0) ||
		(col_next >= rbee_pkg::COL_W'(BYTES_PER_ROW));

	// Number of results this byte produces, and the saturated next index.
	always_comb begin
		n_res = rbee_pkg::CNT_ADD_W'(row_end);
		for (int i = 0; i < rbee_pkg::PIX_W; i++) begin
			n_res = n_res + rbee_pkg::CNT_ADD_W'(mask[i]);
		end
		cnt_sum  = {1'b0, cnt_c} + (rbee_pkg::IDX_W+1)'(n_res);
		cnt_next = cnt_sum[rbee_pkg::IDX_W] ? rbee_pkg::IDX_MAX
			: cnt_sum[rbee_pkg::IDX_W-1:0];
	end

	// Bytes that produce results are handed to the back part.
	always_comb begin
		push          = accept && ((mask != '0) || row_end);
		entry.mask    = mask;
		entry.col     = col_c;
		entry.row_end = row_end;
		entry.first   = !has_edge_c;
		entry.base    = cnt_c;
	end

	// Row state update on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 1'b0;
			col_q      <= '0;
			cnt_q      <= '0;
			has_edge_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= cnt_next;
			if (row_end) begin
				prev_q     <= 1'b0;
				col_q      <= '0;
				has_edge_q <= 1'b0;
			end else begin
				prev_q     <= pixel_byte[0];
				col_q      <= col_next;
				has_edge_q <= has_edge_c || (mask != '0);
			end
		end
	end

endmodule

// ===== hdl/rbee_back.sv =====
// ---------------------------------------------------------------------------
// rbee_back: result emitter of the binary row edge extractor
// Takes classified bytes from the queue and sends one result per cycle when
// not stalled: transitions left to right, then a row terminator where due.
// ---------------------------------------------------------------------------
module rbee_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rbee_pkg::rbee_entry_t        dout,
	input  logic                         empty,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rbee_pkg::PIX_W-1:0]   edge_value,
	output logic [rbee_pkg::IDX_W-1:0]   edge_index,
	output logic                         row_first_edge,
	output logic                         last
);

	logic                         act_valid_q;
	logic [rbee_pkg::PIX_W-1:0]   act_mask_q;
	logic [rbee_pkg::COL_W-1:0]   act_col_q;
	logic                         act_row_end_q;
	logic                         act_first_q;
	logic [rbee_pkg::IDX_W-1:0]   act_idx_q;

	logic                         out_valid_q;
	logic [rbee_pkg::PIX_W-1:0]   out_value_q;
	logic [rbee_pkg::IDX_W-1:0]   out_idx_q;
	logic                         out_first_q;
	logic                         out_last_q;

	logic                         has_bit;
	logic [2:0]                   sel;
	logic [rbee_pkg::PIX_W-1:0]   mask_left;
	logic [rbee_pkg::PIX_W-1:0]   res_value;
	logic                         res_first;
	logic                         is_last;
	logic                         out_free;
	logic                         adv;

	// Leftmost remaining transition (highest set bit) and the mask without it.
	always_comb begin
		sel = '0;
		for (int i = 0; i < rbee_pkg::PIX_W; i++) begin
			if (act_mask_q[i]) begin
				sel = 3'(i);
			end
		end
		has_bit   = (act_mask_q != '0);
		mask_left = act_mask_q & ~(rbee_pkg::PIX_W'(1) << sel);
	end

	// Result for this cycle: x coordinate is column*8 plus 7 minus bit place.
	always_comb begin
		res_value = has_bit ? {act_col_q, ~sel} : rbee_pkg::ROW_END_MARK;
		res_first = has_bit && act_first_q;
		is_last   = has_bit ? ((mask_left == '0) && !act_row_end_q) : 1'b1;
		out_free  = !out_valid_q || out_ready;
		adv       = act_valid_q && out_free;
		pop       = !empty && (!act_valid_q || (adv && is_last));
	end

	// Current byte under emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
		end else if (pop) begin
			act_valid_q <= 1'b1;
		end else if (adv && is_last) begin
			act_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			act_mask_q    <= dout.mask;
			act_col_q     <= dout.col;
			act_row_end_q <= dout.row_end;
			act_first_q   <= dout.first;
			act_idx_q     <= dout.base;
		end else if (adv) begin
			act_mask_q  <= mask_left;
			act_first_q <= act_first_q && !has_bit;
			if (act_idx_q != rbee_pkg::IDX_MAX) begin
				act_idx_q <= act_idx_q + 1'b1;
			end
		end
	end

	// Output register, loaded whenever it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= res_value;
			out_idx_q   <= act_idx_q;
			out_first_q <= res_first;
			out_last_q  <= is_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign edge_value     = out_value_q;
	assign edge_index     = out_idx_q;
	assign row_first_edge = out_first_q;
	assign last           = out_last_q;

	// A byte held for emission always has something left to send.
	a_active_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid_q |-> ((act_mask_q != '0) || act_row_end_q))
		else $error("active byte has no result left");

	// The terminator closes its byte and never carries the first-edge flag.
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_value_q == rbee_pkg::ROW_END_MARK))
			|-> (out_last_q && !out_first_q))
		else $error("row terminator not marked last or marked first edge");

	// A byte that still has results stays active after one is sent.
	a_keep_active: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !is_last) |=> act_valid_q)
		else $error("byte dropped before its last result");

endmodule

// ===== hdl/binary_row_edge_extractor_top.sv =====
// The block takes one packed byte of a binary image (eight pixels, leftmost
// in bit 7) per request and accepts a byte every clock while its four-entry
// queue has room; bytes without transitions that do not end a row never
// enter the queue. The emitter sends at most one result per clock, so a byte
// with k transitions sends k results, plus one for a row terminator, one
// after another; results pass through the queue, the active byte register
// and the output register. Sustained input rate is one byte per clock
// while bytes average no more than one result each and the output is free.
// ---------------------------------------------------------------------------
// binary_row_edge_extractor_top: run-length edge encoder for binary rows
// Front classifier, queue and result emitter joined on stream interfaces.
// ---------------------------------------------------------------------------
module binary_row_edge_extractor_top #(
	parameter int BYTES_PER_ROW = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] pixel_byte
	input  logic        s_tuser,  // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] edge_value, [23:8] edge_index
	output logic        m_tuser,  // [0] row_first_edge
	output logic        m_tlast
);

	rbee_pkg::rbee_entry_t q_din;
	rbee_pkg::rbee_entry_t q_dout;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;
	logic [rbee_pkg::PIX_W-1:0] edge_value;
	logic [rbee_pkg::IDX_W-1:0] edge_index;

	// Classifier on the input side.
	rbee_front #(
		.BYTES_PER_ROW(BYTES_PER_ROW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.pixel_byte (s_tdata),
		.frame_start(s_tuser),
		.push       (q_push),
		.entry      (q_din),
		.full       (q_full)
	);

	// Queue between the two sides.
	rbee_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	// Result emitter on the output side.
	rbee_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.dout          (q_dout),
		.empty         (q_empty),
		.pop           (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.edge_value    (edge_value),
		.edge_index    (edge_index),
		.row_first_edge(m_tuser),
		.last          (m_tlast)
	);

	assign m_tdata = {edge_index, edge_value};

endmodule
